>>> design/ioc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I/O credit controller package
// Shared types, codes and constants for the arcade I/O and credit controller.
// ----------------------------------------------------------------------------
package ioc_pkg;

   localparam int unsigned CSR_DATA_W = 16;

   typedef enum logic [1:0] {
      ACT_READ      = 2'd0,
      ACT_WRITE     = 2'd1,
      ACT_TICK      = 2'd2,
      ACT_EXT_RESET = 2'd3
   } action_type;

   typedef enum logic {
      CSR_BUSY_DELAY = 1'b0,
      CSR_FIRE_HOLD  = 1'b1
   } csr_index_type;

   localparam logic [7:0] DATA_CMD_SETUP      = 8'h01;
   localparam logic [7:0] DATA_CMD_CREDIT_ON  = 8'h02;
   localparam logic [7:0] DATA_CMD_CREDIT_OFF = 8'h05;

   localparam logic [15:0] BUSY_DELAY_RESET = 16'd5000;
   localparam logic [2:0]  FIRE_HOLD_RESET  = 3'd1;
   localparam logic [7:0]  STATUS_READY     = 8'h10;
   localparam logic [7:0]  CTRL_EXPLOSION   = 8'hA8;
   localparam logic [6:0]  CREDIT_MAX       = 7'd99;
   localparam logic [2:0]  SETUP_BYTES      = 3'd4;
   localparam logic [1:0]  LAST_INDEX       = 2'd3;
   localparam logic [7:0]  ALL_HIGH         = 8'hFF;

   localparam int unsigned KEY_LEFT  = 0;
   localparam int unsigned KEY_UP    = 1;
   localparam int unsigned KEY_RIGHT = 2;
   localparam int unsigned KEY_DOWN  = 3;
   localparam int unsigned KEY_FIRE  = 4;
   localparam int unsigned KEY_START = 5;
   localparam int unsigned KEY_COIN  = 6;

   typedef struct packed {
      action_type  action;
      logic        reg_select;
      logic [7:0]  write_value;
      logic [6:0]  buttons;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       nmi_pulse;
      logic       explosion_trigger;
   } rsp_type;

   // tens by reciprocal multiply, exact for values below 180
   function automatic logic [7:0] to_bcd(input logic [6:0] value);
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [6:0]  units;
      prod  = 15'(value) * 15'd205;
      tens  = prod[14:11];
      units = value - 7'(tens) * 7'd10;
      return {tens, units[3:0]};
   endfunction

endpackage

>>> design/ioc_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I/O credit controller input stage
// Request register with valid flag; hands the request on when the result
// register can take it.
// ----------------------------------------------------------------------------
module ioc_in_stage (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  ioc_pkg::req_type req_in,
   input  logic            out_free,
   output logic            advance,
   output ioc_pkg::req_type item
);
   import ioc_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type item_ff;

   assign advance   = valid_ff & out_free;
   assign req_ready = ~valid_ff | advance;
   assign valid_in  = (req_valid & req_ready) | (valid_ff & ~advance);
   assign item      = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // hold the request until it moves on
   always_ff @(posedge clock) begin
      if (req_valid & req_ready) begin
         item_ff <= req_in;
      end
   end

endmodule

>>> design/ioc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I/O credit controller core
// Device state, configuration registers and the single-pass request update.
// ----------------------------------------------------------------------------
module ioc_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write,
   input  logic                            csr_index,
   input  logic [ioc_pkg::CSR_DATA_W-1:0]  csr_data,
   input  logic                            advance,
   input  ioc_pkg::req_type                item,
   output ioc_pkg::rsp_type                result
);
   import ioc_pkg::*;

   logic [15:0] busy_delay_ff;
   logic [2:0]  fire_hold_reads_ff;

   logic [7:0]  control_ff,   control_in;
   logic [1:0]  index_ff,     index_in;
   logic [15:0] busy_ff,      busy_in;
   logic        credit_en_ff, credit_en_in;
   logic [6:0]  credit_ff,    credit_in;
   logic [2:0]  setup_ff,     setup_in;
   logic [8:0]  nmi_ff,       nmi_in;
   logic [6:0]  prev_ff,      prev_in;
   logic [2:0]  fire_hold_ff, fire_hold_in;

   logic [6:0]  pressed;
   logic [7:0]  joy;
   logic [7:0]  credit_bcd;
   logic [6:0]  credit_dec;
   logic [1:0]  index_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_delay_ff      <= BUSY_DELAY_RESET;
         fire_hold_reads_ff <= FIRE_HOLD_RESET;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_BUSY_DELAY: busy_delay_ff      <= csr_data[15:0];
            CSR_FIRE_HOLD:  fire_hold_reads_ff <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   assign pressed    = item.buttons & ~prev_ff;
   assign credit_bcd = to_bcd(credit_ff);
   assign index_next = (index_ff == LAST_INDEX) ? index_ff : index_ff + 2'd1;

   always_comb begin
      control_in   = control_ff;
      index_in     = index_ff;
      busy_in      = busy_ff;
      credit_en_in = credit_en_ff;
      credit_in    = credit_ff;
      setup_in     = setup_ff;
      nmi_in       = nmi_ff;
      prev_in      = prev_ff;
      fire_hold_in = fire_hold_ff;
      joy          = ALL_HIGH;
      credit_dec   = credit_ff;
      result       = '0;

      unique case (item.action)
         ACT_READ: begin
            if (item.reg_select) begin
               result.read_data = (busy_ff != 16'd0) ? 8'h00 : STATUS_READY;
            end else if (!control_ff[0]) begin
               result.read_data = 8'h00;
            end else if (!credit_en_ff) begin
               result.read_data = ALL_HIGH;
               index_in         = index_next;
            end else begin
               joy[3] = ~item.buttons[KEY_LEFT];
               joy[2] = ~item.buttons[KEY_UP];
               joy[1] = ~item.buttons[KEY_RIGHT];
               joy[0] = ~item.buttons[KEY_DOWN];
               if (pressed[KEY_FIRE]) begin
                  joy[4]       = 1'b0;
                  fire_hold_in = fire_hold_reads_ff;
               end else if (fire_hold_ff != 3'd0) begin
                  joy[4]       = 1'b0;
                  fire_hold_in = fire_hold_ff - 3'd1;
               end
               if (pressed[KEY_START] && credit_ff != 7'd0) begin
                  credit_dec = credit_ff - 7'd1;
               end
               credit_in = credit_dec;
               if (pressed[KEY_COIN] && credit_dec < CREDIT_MAX) begin
                  credit_in = credit_dec + 7'd1;
               end
               case (index_ff)
                  2'd0:    result.read_data = credit_bcd;
                  2'd1:    result.read_data = joy;
                  default: result.read_data = ALL_HIGH;
               endcase
               if (index_ff != LAST_INDEX) begin
                  prev_in  = item.buttons;
                  index_in = index_next;
               end
            end
         end
         ACT_WRITE: begin
            if (item.reg_select) begin
               index_in   = 2'd0;
               control_in = item.write_value;
               busy_in    = busy_delay_ff;
               result.explosion_trigger = (item.write_value == CTRL_EXPLOSION);
            end else if (control_ff[0]) begin
               if (setup_ff != 3'd0) begin
                  setup_in = setup_ff - 3'd1;
               end else begin
                  case (item.write_value)
                     DATA_CMD_SETUP:      setup_in     = SETUP_BYTES;
                     DATA_CMD_CREDIT_ON:  credit_en_in = 1'b1;
                     DATA_CMD_CREDIT_OFF: credit_en_in = 1'b0;
                     default: ;
                  endcase
                  index_in = index_next;
               end
            end
         end
         ACT_TICK: begin
            if (busy_ff != 16'd0) begin
               busy_in = busy_ff - 16'd1;
            end
            if (control_ff[7:5] != 3'd0) begin
               if (nmi_ff < {control_ff[7:5], 6'd0}) begin
                  nmi_in = nmi_ff + 9'd1;
               end else begin
                  nmi_in           = 9'd0;
                  result.nmi_pulse = 1'b1;
               end
            end
         end
         ACT_EXT_RESET: begin
            credit_en_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         control_ff   <= '0;
         index_ff     <= '0;
         busy_ff      <= '0;
         credit_en_ff <= 1'b0;
         credit_ff    <= '0;
         setup_ff     <= '0;
         nmi_ff       <= '0;
         prev_ff      <= '0;
         fire_hold_ff <= '0;
      end else if (advance) begin
         control_ff   <= control_in;
         index_ff     <= index_in;
         busy_ff      <= busy_in;
         credit_en_ff <= credit_en_in;
         credit_ff    <= credit_in;
         setup_ff     <= setup_in;
         nmi_ff       <= nmi_in;
         prev_ff      <= prev_in;
         fire_hold_ff <= fire_hold_in;
      end
   end

endmodule

>>> design/ioc_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I/O credit controller result stage
// Result register; holds a result until the consumer takes it.
// ----------------------------------------------------------------------------
module ioc_out_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  ioc_pkg::rsp_type result,
   output logic             out_free,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ioc_pkg::rsp_type rsp
);
   import ioc_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type rsp_ff;

   assign out_free  = ~valid_ff | rsp_ready;
   assign valid_in  = advance | (valid_ff & ~rsp_ready);
   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

endmodule

>>> design/arcade_io_credit_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Arcade I/O and credit controller
// Control/data register pair with credit counting, joystick reads, busy
// countdown and NMI pacing.
// ----------------------------------------------------------------------------
// Takes one request per clock unless a result is held back. A request is
// registered on acceptance, evaluated against the device state in the request
// register, and its result lands in the result register when that is free.
// req_ready is low only while a request waits behind a result that rsp_ready
// has not taken. Register writes on the csr_ port take effect at once; the user
// must make them while no request is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module arcade_io_credit_controller (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write,
   input  logic                           csr_index,
   input  logic [ioc_pkg::CSR_DATA_W-1:0] csr_data,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_action,
   input  logic                           req_reg_select,
   input  logic [7:0]                     req_write_value,
   input  logic [6:0]                     req_buttons,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [7:0]                     rsp_read_data,
   output logic                           rsp_nmi_pulse,
   output logic                           rsp_explosion_trigger
);
   import ioc_pkg::*;

   req_type req_in;
   req_type item;
   rsp_type result;
   rsp_type rsp;
   logic    advance;
   logic    out_free;

   assign req_in.action      = action_type'(req_action);
   assign req_in.reg_select  = req_reg_select;
   assign req_in.write_value = req_write_value;
   assign req_in.buttons     = req_buttons;

   ioc_in_stage u_in (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_in    (req_in),
      .out_free  (out_free),
      .advance   (advance),
      .item      (item)
   );

   ioc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .advance   (advance),
      .item      (item),
      .result    (result)
   );

   ioc_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .result    (result),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_read_data         = rsp.read_data;
   assign rsp_nmi_pulse         = rsp.nmi_pulse;
   assign rsp_explosion_trigger = rsp.explosion_trigger;

endmodule

>>> design/ioc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I/O credit controller checker
// Port-level properties of the controller, bound to the top level.
// ----------------------------------------------------------------------------
module ioc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_read_data,
   input logic       rsp_nmi_pulse,
   input logic       rsp_explosion_trigger
);

   // no result straight after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a held result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // an NMI comes only from a tick, which returns no data
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_nmi_pulse |-> rsp_read_data == 8'h00 && !rsp_explosion_trigger)
      else $error("NMI pulse on a non-tick result");

   // an explosion trigger comes only from a control write
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_explosion_trigger |-> rsp_read_data == 8'h00)
      else $error("explosion trigger with read data");

   // an empty pipeline with no request offered goes on to take requests
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !req_valid |=> req_ready)
      else $error("request refused with empty pipeline");

endmodule

bind arcade_io_credit_controller ioc_checker u_ioc_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_valid             (req_valid),
   .req_ready             (req_ready),
   .rsp_valid             (rsp_valid),
   .rsp_ready             (rsp_ready),
   .rsp_read_data         (rsp_read_data),
   .rsp_nmi_pulse         (rsp_nmi_pulse),
   .rsp_explosion_trigger (rsp_explosion_trigger)
);

>>> bench/arcade_io_credit_controller_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Arcade I/O and credit controller testbench
// Feeds directed and random bus requests (register reads and writes, ticks,
// external resets) through the request channel under random back-pressure,
// tracks the device state alongside the block and checks every response in
// order, field by field. Register settings change between idle phases.
// ----------------------------------------------------------------------------
module arcade_io_credit_controller_tb;
   import ioc_pkg::*;

   localparam int CLK_HALF    = 6;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;

   logic                  clock           = 1'b0;
   logic                  reset           = 1'b1;
   logic                  csr_write       = 1'b0;
   csr_index_type         csr_index       = CSR_BUSY_DELAY;
   logic [CSR_DATA_W-1:0] csr_data        = '0;
   logic                  req_valid       = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_action      = '0;
   logic                  req_reg_select  = 1'b0;
   logic [7:0]            req_write_value = '0;
   logic [6:0]            req_buttons     = '0;
   logic                  rsp_valid;
   logic                  rsp_ready       = 1'b0;
   logic [7:0]            rsp_read_data;
   logic                  rsp_nmi_pulse;
   logic                  rsp_explosion_trigger;

   // device state as tracked by the bench
   logic [15:0] cfg_busy_delay;
   logic [2:0]  cfg_fire_hold;
   logic [7:0]  dev_ctrl;
   logic [1:0]  dev_index;
   logic [15:0] dev_busy;
   logic        dev_credit_mode;
   logic [6:0]  dev_credits;
   logic [2:0]  dev_setup_left;
   logic [8:0]  dev_nmi_count;
   logic [6:0]  dev_prev_keys;
   logic [2:0]  dev_fire_hold;

   req_type req_pending[$];
   rsp_type replies_due[$];
   req_type req_offered;
   rsp_type reply_want;

   int   mismatches  = 0;
   int   cycle_count = 0;
   int   hold_left   = 0;
   logic hold_done   = 1'b0;
   logic hold_req    = 1'b0;
   logic steady      = 1'b0;

   arcade_io_credit_controller dut (
      .clock                 (clock),
      .reset                 (reset),
      .csr_write             (csr_write),
      .csr_index             (csr_index),
      .csr_data              (csr_data),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_action            (req_action),
      .req_reg_select        (req_reg_select),
      .req_write_value       (req_write_value),
      .req_buttons           (req_buttons),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_read_data         (rsp_read_data),
      .rsp_nmi_pulse         (rsp_nmi_pulse),
      .rsp_explosion_trigger (rsp_explosion_trigger)
   );

   always #(CLK_HALF) clock = ~clock;

   function automatic rsp_type model_io_access(input req_type r);
      rsp_type    rsp;
      logic [6:0] pressed;
      logic [7:0] joy;
      logic [7:0] bcd;
      rsp = '0;
      case (r.action)
         ACT_READ: begin
            if (r.reg_select) begin
               rsp.read_data = (dev_busy == 16'd0) ? STATUS_READY : 8'h00;
            end else if (!dev_ctrl[0]) begin
               rsp.read_data = 8'h00;
            end else if (!dev_credit_mode) begin
               rsp.read_data = ALL_HIGH;
               if (dev_index != LAST_INDEX) dev_index = dev_index + 2'd1;
            end else begin
               pressed = r.buttons & ~dev_prev_keys;
               joy     = ALL_HIGH;
               joy[3]  = ~r.buttons[KEY_LEFT];
               joy[2]  = ~r.buttons[KEY_UP];
               joy[1]  = ~r.buttons[KEY_RIGHT];
               joy[0]  = ~r.buttons[KEY_DOWN];
               if (pressed[KEY_FIRE]) begin
                  joy[4]        = 1'b0;
                  dev_fire_hold = cfg_fire_hold;
               end else if (dev_fire_hold != 3'd0) begin
                  joy[4]        = 1'b0;
                  dev_fire_hold = dev_fire_hold - 3'd1;
               end
               bcd = {4'(dev_credits / 7'd10), 4'(dev_credits % 7'd10)};
               if (pressed[KEY_START] && dev_credits != 7'd0)
                  dev_credits = dev_credits - 7'd1;
               if (pressed[KEY_COIN] && dev_credits < CREDIT_MAX)
                  dev_credits = dev_credits + 7'd1;
               if (dev_index == LAST_INDEX) begin
                  rsp.read_data = ALL_HIGH;
               end else begin
                  dev_prev_keys = r.buttons;
                  if (dev_index == 2'd0)
                     rsp.read_data = bcd;
                  else if (dev_index == 2'd1)
                     rsp.read_data = joy;
                  else
                     rsp.read_data = ALL_HIGH;
                  dev_index = dev_index + 2'd1;
               end
            end
         end
         ACT_WRITE: begin
            if (r.reg_select) begin
               dev_index             = 2'd0;
               dev_ctrl              = r.write_value;
               dev_busy              = cfg_busy_delay;
               rsp.explosion_trigger = (r.write_value == CTRL_EXPLOSION);
            end else if (dev_ctrl[0]) begin
               if (dev_setup_left != 3'd0) begin
                  dev_setup_left = dev_setup_left - 3'd1;
               end else begin
                  if (r.write_value == DATA_CMD_SETUP)
                     dev_setup_left = SETUP_BYTES;
                  else if (r.write_value == DATA_CMD_CREDIT_ON)
                     dev_credit_mode = 1'b1;
                  else if (r.write_value == DATA_CMD_CREDIT_OFF)
                     dev_credit_mode = 1'b0;
                  if (dev_index != LAST_INDEX) dev_index = dev_index + 2'd1;
               end
            end
         end
         ACT_TICK: begin
            if (dev_busy != 16'd0) dev_busy = dev_busy - 16'd1;
            if (dev_ctrl[7:5] != 3'd0) begin
               if (dev_nmi_count < {dev_ctrl[7:5], 6'd0}) begin
                  dev_nmi_count = dev_nmi_count + 9'd1;
               end else begin
                  rsp.nmi_pulse = 1'b1;
                  dev_nmi_count = 9'd0;
               end
            end
         end
         default: begin
            dev_credit_mode = 1'b0;
         end
      endcase
      return rsp;
   endfunction

   task automatic queue_req(input action_type act, input logic sel, input logic [7:0] wv,
                            input logic [6:0] keys);
      req_type r;
      r.action      = act;
      r.reg_select  = sel;
      r.write_value = wv;
      r.buttons     = keys;
      req_pending.push_back(r);
   endtask

   task automatic set_registers(input logic [15:0] busy_delay, input logic [2:0] fire_hold);
      @(posedge clock);
      csr_write      <= 1'b1;
      csr_index      <= CSR_BUSY_DELAY;
      csr_data       <= busy_delay;
      cfg_busy_delay  = busy_delay;
      @(posedge clock);
      csr_index      <= CSR_FIRE_HOLD;
      csr_data       <= {13'($urandom), fire_hold};
      cfg_fire_hold   = fire_hold;
      @(posedge clock);
      csr_write      <= 1'b0;
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (req_pending.size() != 0 || req_valid || replies_due.size() != 0);
   endtask

   task automatic add_random(input int count);
      int         target;
      int         kind;
      int         n;
      logic [7:0] v;
      target = req_pending.size() + count;
      while (req_pending.size() < target) begin
         kind = $urandom_range(0, 99);
         if (kind < 8) begin
            if ($urandom_range(0, 7) == 0)
               v = CTRL_EXPLOSION;
            else if ($urandom_range(0, 4) == 0)
               v = 8'($urandom);
            else
               v = {3'($urandom), 4'($urandom), 1'b1};
            queue_req(ACT_WRITE, 1'b1, v, 7'($urandom));
         end else if (kind < 16) begin
            case ($urandom_range(0, 3))
               0:       v = DATA_CMD_SETUP;
               1:       v = DATA_CMD_CREDIT_ON;
               2:       v = DATA_CMD_CREDIT_OFF;
               default: v = 8'($urandom);
            endcase
            queue_req(ACT_WRITE, 1'b0, v, 7'($urandom));
            if (v == DATA_CMD_SETUP)
               repeat (4) queue_req(ACT_WRITE, 1'b0, 8'($urandom), 7'($urandom));
         end else if (kind < 50) begin
            // select the device, mostly enter credit mode, then read a burst of bytes
            v = {($urandom_range(0, 2) == 0) ? 3'($urandom) : 3'd1, 4'($urandom), 1'b1};
            queue_req(ACT_WRITE, 1'b1, v, 7'($urandom));
            if ($urandom_range(0, 5) != 0)
               queue_req(ACT_WRITE, 1'b0, DATA_CMD_CREDIT_ON, 7'($urandom));
            n = $urandom_range(1, 5);
            repeat (n) queue_req(ACT_READ, 1'b0, 8'($urandom), 7'($urandom));
         end else if (kind < 62) begin
            n = $urandom_range(1, 120);
            repeat (n) queue_req(ACT_TICK, 1'($urandom), 8'($urandom), 7'($urandom));
         end else if (kind < 72) begin
            queue_req(ACT_READ, 1'b1, 8'($urandom), 7'($urandom));
         end else if (kind < 80) begin
            queue_req(ACT_READ, 1'b0, 8'($urandom), 7'($urandom));
         end else if (kind < 86) begin
            queue_req(ACT_EXT_RESET, 1'($urandom), 8'($urandom), 7'($urandom));
         end else begin
            queue_req(action_type'($urandom_range(0, 3)), 1'($urandom), 8'($urandom),
                      7'($urandom));
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            replies_due.push_back(model_io_access(req_offered));
         end
         if (!req_valid || req_ready) begin
            if (req_pending.size() != 0 && (steady || $urandom_range(0, 99) >= 24)) begin
               req_offered      = req_pending.pop_front();
               req_valid       <= 1'b1;
               req_action      <= req_offered.action;
               req_reg_select  <= req_offered.reg_select;
               req_write_value <= req_offered.write_value;
               req_buttons     <= req_offered.buttons;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (replies_due.size() == 0) begin
            $display("%0t: unexpected response: read_data %h nmi_pulse %b explosion %b",
                     $realtime, rsp_read_data, rsp_nmi_pulse, rsp_explosion_trigger);
            mismatches++;
         end else begin
            reply_want = replies_due.pop_front();
            if (rsp_read_data !== reply_want.read_data) begin
               $display("%0t: read_data expected %h actual %h",
                        $realtime, reply_want.read_data, rsp_read_data);
               mismatches++;
            end
            if (rsp_nmi_pulse !== reply_want.nmi_pulse) begin
               $display("%0t: nmi_pulse expected %b actual %b",
                        $realtime, reply_want.nmi_pulse, rsp_nmi_pulse);
               mismatches++;
            end
            if (rsp_explosion_trigger !== reply_want.explosion_trigger) begin
               $display("%0t: explosion_trigger expected %b actual %b",
                        $realtime, reply_want.explosion_trigger, rsp_explosion_trigger);
               mismatches++;
            end
         end
      end
      // hold the receiver off once so the request side backs up
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_req && !hold_done) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_ready <= steady || $urandom_range(0, 99) >= 24;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("arcade_io_credit_controller test failed");
         $finish;
      end
   end

   initial begin
      cfg_busy_delay  = BUSY_DELAY_RESET;
      cfg_fire_hold   = FIRE_HOLD_RESET;
      dev_ctrl        = '0;
      dev_index       = '0;
      dev_busy        = '0;
      dev_credit_mode = 1'b0;
      dev_credits     = '0;
      dev_setup_left  = '0;
      dev_nmi_count   = '0;
      dev_prev_keys   = '0;
      dev_fire_hold   = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      queue_req(ACT_READ, 1'b1, 8'h00, 7'h00);
      queue_req(ACT_READ, 1'b0, 8'h00, 7'h7F);
      queue_req(ACT_WRITE, 1'b0, DATA_CMD_CREDIT_ON, 7'h00);
      queue_req(ACT_TICK, 1'b0, 8'hFF, 7'h00);
      queue_req(ACT_EXT_RESET, 1'b1, 8'hFF, 7'h7F);
      queue_req(ACT_WRITE, 1'b1, CTRL_EXPLOSION, 7'h00);
      queue_req(ACT_WRITE, 1'b1, 8'h01, 7'h00);
      queue_req(ACT_READ, 1'b1, 8'h00, 7'h00);
      repeat (4) queue_req(ACT_READ, 1'b0, 8'h00, 7'h00);
      queue_req(ACT_WRITE, 1'b1, 8'h01, 7'h00);
      queue_req(ACT_WRITE, 1'b0, DATA_CMD_SETUP, 7'h00);
      queue_req(ACT_WRITE, 1'b0, 8'hFF, 7'h00);
      queue_req(ACT_WRITE, 1'b0, 8'h00, 7'h00);
      queue_req(ACT_WRITE, 1'b0, DATA_CMD_CREDIT_ON, 7'h00);
      queue_req(ACT_WRITE, 1'b0, DATA_CMD_CREDIT_OFF, 7'h00);
      queue_req(ACT_WRITE, 1'b0, DATA_CMD_CREDIT_ON, 7'h00);
      queue_req(ACT_WRITE, 1'b1, 8'h01, 7'h00);
      queue_req(ACT_READ, 1'b0, 8'h00, 7'h40);
      queue_req(ACT_READ, 1'b0, 8'h00, 7'h11);
      queue_req(ACT_READ, 1'b0, 8'h00, 7'h7F);
      queue_req(ACT_READ, 1'b0, 8'h00, 7'h20);
      queue_req(ACT_EXT_RESET, 1'b0, 8'h00, 7'h00);
      add_random(220);
      wait_idle();

      set_registers(16'd0, 3'd0);
      hold_req = 1'b1;
      add_random(220);
      wait_idle();

      set_registers(16'hFFFF, 3'd7);
      steady = 1'b1;
      add_random(230);
      wait_idle();
      steady = 1'b0;

      set_registers(16'($urandom_range(1, 40)), 3'($urandom_range(2, 6)));
      add_random(230);
      wait_idle();

      repeat (8) @(posedge clock);
      if (mismatches == 0 && replies_due.size() == 0) begin
         $display("arcade_io_credit_controller test passed");
      end else begin
         $display("arcade_io_credit_controller test failed");
      end
      $finish;
   end

endmodule
